// ----- hdl/brc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the block run coalescer.
// No dependencies; used by every module under hdl.
package brc_pkg;

   localparam int unsigned PtrWidth     = 32;
   localparam int unsigned LenWidth     = 7;
   localparam int unsigned SpbWidth     = 8;
   localparam int unsigned SectorWidth  = 40;
   localparam int unsigned SecCntWidth  = 14;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 32;

   // longest run merged into one request
   localparam logic [LenWidth-1:0] RunCap = 7'd64;

   // request queue between coalescer and sector stage (power of two)
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QPtrWidth  = $clog2(QueueDepth);
   localparam int unsigned QCntWidth  = $clog2(QueueDepth + 1);

   // register indexes on the csr port
   localparam logic [CsrIdxWidth-1:0] CsrPartitionStart = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrSectorsPerBlk  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrMaxRunBlocks   = 2'd2;

   // reset values
   localparam logic [CsrDataWidth-1:0] PartitionStartRst = 32'd0;
   localparam logic [SpbWidth-1:0]     SectorsPerBlkRst  = 8'd2;
   localparam logic [LenWidth-1:0]     MaxRunBlocksRst   = 7'd64;

   typedef struct packed {
      logic [CsrDataWidth-1:0] partition_start;
      logic [SpbWidth-1:0]     sectors_per_block;
      logic [LenWidth-1:0]     max_run_blocks;
   } brc_cfg_type;

   // one read request in block terms, before sector arithmetic
   typedef struct packed {
      logic [PtrWidth-1:0] first_block;
      logic [LenWidth-1:0] block_count;
      logic                final_request;
   } brc_req_type;

endpackage

// ----- hdl/brc_coalesce.sv -----
`timescale 1ns / 1ps
// Run tracking: merges consecutive block pointers and emits up to two
// requests per transfer. Depends on brc_pkg.
module brc_coalesce (
   input  logic                              clock,
   input  logic                              reset,
   input  brc_pkg::brc_cfg_type              cfg,
   input  logic                              accept,
   input  logic [brc_pkg::PtrWidth-1:0]      pointer_value,
   input  logic                              last_in_block,
   output logic [1:0]                        push_cnt,
   output brc_pkg::brc_req_type              push_req0,
   output brc_pkg::brc_req_type              push_req1
);

   logic [brc_pkg::PtrWidth-1:0] run_first_ff, run_first_in;
   logic [brc_pkg::LenWidth-1:0] run_len_ff, run_len_in;
   logic                         run_open_ff, run_open_in;
   logic                         stopped_ff, stopped_in;

   logic [brc_pkg::LenWidth-1:0] run_limit;
   logic                         extend;
   logic                         emit_old;
   logic                         emit_new;
   brc_pkg::brc_req_type         old_req;
   brc_pkg::brc_req_type         new_req;

   always_comb begin
      priority if (cfg.max_run_blocks == '0) begin
         run_limit = brc_pkg::LenWidth'(1);
      end else if (cfg.max_run_blocks > brc_pkg::RunCap) begin
         run_limit = brc_pkg::RunCap;
      end else begin
         run_limit = cfg.max_run_blocks;
      end
   end

   assign extend = run_open_ff && (run_len_ff < run_limit) &&
                   ((33'(run_first_ff) + 33'(run_len_ff)) == 33'(pointer_value));

   always_comb begin
      run_first_in = run_first_ff;
      run_len_in   = run_len_ff;
      run_open_in  = run_open_ff;
      stopped_in   = stopped_ff;
      emit_old     = 1'b0;
      emit_new     = 1'b0;
      old_req      = '{first_block: run_first_ff, block_count: run_len_ff,
                       final_request: 1'b1};
      new_req      = '{first_block: run_first_ff, block_count: run_len_ff,
                       final_request: 1'b1};
      priority if (stopped_ff) begin
         // rest of the pointer block is skipped
         stopped_in = !last_in_block;
      end else if (pointer_value == '0) begin
         emit_old     = run_open_ff;
         run_first_in = '0;
         run_len_in   = '0;
         run_open_in  = 1'b0;
         stopped_in   = !last_in_block;
      end else begin
         if (extend) begin
            run_len_in = run_len_ff + brc_pkg::LenWidth'(1);
         end else begin
            emit_old      = run_open_ff;
            old_req.final_request = !last_in_block;
            run_first_in  = pointer_value;
            run_len_in    = brc_pkg::LenWidth'(1);
            run_open_in   = 1'b1;
         end
         if (last_in_block) begin
            emit_new     = 1'b1;
            new_req      = '{first_block: run_first_in, block_count: run_len_in,
                             final_request: 1'b1};
            run_first_in = '0;
            run_len_in   = '0;
            run_open_in  = 1'b0;
         end
      end
   end

   // compact the emitted requests so the first one always sits in slot 0
   always_comb begin
      push_req0 = emit_old ? old_req : new_req;
      push_req1 = new_req;
      if (accept) begin
         push_cnt = {1'b0, emit_old} + {1'b0, emit_new};
      end else begin
         push_cnt = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_first_ff <= '0;
         run_len_ff   <= '0;
         run_open_ff  <= 1'b0;
         stopped_ff   <= 1'b0;
      end else if (accept) begin
         run_first_ff <= run_first_in;
         run_len_ff   <= run_len_in;
         run_open_ff  <= run_open_in;
         stopped_ff   <= stopped_in;
      end
   end

`ifndef ASSERT_OFF
   a_open_len: assert property (@(posedge clock) disable iff (reset)
      run_open_ff |-> (run_len_ff != '0) && (run_len_ff <= brc_pkg::RunCap))
      else $error("open run has bad length");
   a_closed_len: assert property (@(posedge clock) disable iff (reset)
      !run_open_ff |-> (run_len_ff == '0))
      else $error("closed run keeps a length");
`endif

endmodule

// ----- hdl/brc_queue.sv -----
`timescale 1ns / 1ps
// Small request queue: up to two writes per cycle, one read.
// Depends on brc_pkg.
module brc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_cnt,
   input  brc_pkg::brc_req_type  push_req0,
   input  brc_pkg::brc_req_type  push_req1,
   input  logic                  pop,
   output logic                  head_valid,
   output brc_pkg::brc_req_type  head_req,
   output logic                  almost_full
);

   brc_pkg::brc_req_type                entry_ff [brc_pkg::QueueDepth];
   logic [brc_pkg::QPtrWidth-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [brc_pkg::QPtrWidth-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [brc_pkg::QCntWidth-1:0]       count_ff, count_in;
   logic [brc_pkg::QPtrWidth-1:0]       wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + brc_pkg::QPtrWidth'(1);
   assign wr_ptr_in   = wr_ptr_ff + brc_pkg::QPtrWidth'(push_cnt);
   assign rd_ptr_in   = rd_ptr_ff + brc_pkg::QPtrWidth'(pop);
   assign count_in    = count_ff + brc_pkg::QCntWidth'(push_cnt)
                        - brc_pkg::QCntWidth'(pop);

   assign head_valid  = (count_ff != '0);
   assign head_req    = entry_ff[rd_ptr_ff];
   // leave room for the two requests one transfer can cause
   assign almost_full = (count_ff > brc_pkg::QCntWidth'(brc_pkg::QueueDepth - 2));

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_req0;
      end
      if (push_cnt == 2'd2) begin
         entry_ff[wr_ptr_next] <= push_req1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push_cnt != 2'd0) |-> (count_ff <= brc_pkg::QCntWidth'(brc_pkg::QueueDepth - 2)))
      else $error("request queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty request queue");
`endif

endmodule

// ----- hdl/brc_sector.sv -----
`timescale 1ns / 1ps
// Sector arithmetic: multiply stage then partition offset add, with
// back-pressure from the response channel. Depends on brc_pkg.
module brc_sector (
   input  logic                               clock,
   input  logic                               reset,
   input  brc_pkg::brc_cfg_type               cfg,
   input  logic                               head_valid,
   input  brc_pkg::brc_req_type               head_req,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [brc_pkg::PtrWidth-1:0]       rsp_start_block,
   output logic [brc_pkg::LenWidth-1:0]       rsp_block_count,
   output logic [brc_pkg::SectorWidth-1:0]    rsp_start_sector,
   output logic [brc_pkg::SecCntWidth-1:0]    rsp_sector_count,
   output logic                               rsp_final_request
);

   // multiply stage
   logic                               mul_valid_ff, mul_valid_in;
   brc_pkg::brc_req_type               mul_req_ff;
   logic [brc_pkg::SectorWidth-1:0]    mul_prod_ff, mul_prod_in;
   logic [brc_pkg::SecCntWidth-1:0]    mul_cnt_ff, mul_cnt_in;
   logic [brc_pkg::LenWidth+brc_pkg::SpbWidth-1:0] cnt_full;

   // output stage
   logic                               out_valid_ff, out_valid_in;
   brc_pkg::brc_req_type               out_req_ff;
   logic [brc_pkg::SectorWidth-1:0]    out_sector_ff, out_sector_in;
   logic [brc_pkg::SecCntWidth-1:0]    out_cnt_ff;

   logic load_mul;
   logic load_out;

   assign load_out = mul_valid_ff && (!out_valid_ff || !rsp_stall);
   assign load_mul = head_valid && (!mul_valid_ff || load_out);
   assign pop      = load_mul;

   assign mul_prod_in = brc_pkg::SectorWidth'(head_req.first_block) *
                        brc_pkg::SectorWidth'(cfg.sectors_per_block);
   assign cnt_full    = head_req.block_count * cfg.sectors_per_block;
   assign mul_cnt_in  = cnt_full[brc_pkg::SecCntWidth-1:0];

   assign out_sector_in = brc_pkg::SectorWidth'(cfg.partition_start) + mul_prod_ff;

   assign mul_valid_in = load_mul || (mul_valid_ff && !load_out);
   assign out_valid_in = load_out || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_mul) begin
         mul_req_ff  <= head_req;
         mul_prod_ff <= mul_prod_in;
         mul_cnt_ff  <= mul_cnt_in;
      end
      if (load_out) begin
         out_req_ff    <= mul_req_ff;
         out_sector_ff <= out_sector_in;
         out_cnt_ff    <= mul_cnt_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_start_block   = out_req_ff.first_block;
   assign rsp_block_count   = out_req_ff.block_count;
   assign rsp_start_sector  = out_sector_ff;
   assign rsp_sector_count  = out_cnt_ff;
   assign rsp_final_request = out_req_ff.final_request;

endmodule

// ----- hdl/block_run_coalescer.sv -----
`timescale 1ns / 1ps
// Block run coalescer: turns a stream of block pointers into read requests
// for runs of consecutive blocks.
// Input channel req_*: one block pointer per transfer, last_in_block set on
//    the final pointer of a pointer block. A zero pointer ends the list and
//    the rest of that pointer block is dropped.
// Result channel rsp_*: start block, block count, start sector
//    (partition_start + block * sectors_per_block) and sector count.
//    final_request marks the last request caused by one input transfer.
// csr_*: write-only registers (0 partition start, 1 sectors per block,
//    2 maximum run length); write them only while the block is idle.
// Throughput: one pointer per cycle unless req_stall is high. Two requests
//    from one transfer leave one after the other on the result channel, and
//    the four-entry request queue raises req_stall once it holds more than two.
// Path: a request reaches rsp_valid after the transfer that closes its run,
//    through the queue write on the transfer edge, then the multiply stage
//    and the offset add stage; the second of two requests from one transfer
//    follows it.
// Reset (synchronous) empties the pipeline, closes any open run and loads
//    the register defaults. While rsp_stall is high the result holds and the
//    queue fills until req_stall pushes back on the input.
module block_run_coalescer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [brc_pkg::PtrWidth-1:0]          req_pointer_value,
   input  logic                                  req_last_in_block,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [brc_pkg::PtrWidth-1:0]          rsp_start_block,
   output logic [brc_pkg::LenWidth-1:0]          rsp_block_count,
   output logic [brc_pkg::SectorWidth-1:0]       rsp_start_sector,
   output logic [brc_pkg::SecCntWidth-1:0]       rsp_sector_count,
   output logic                                  rsp_final_request,
   input  logic                                  csr_wr_en,
   input  logic [brc_pkg::CsrIdxWidth-1:0]       csr_index,
   input  logic [brc_pkg::CsrDataWidth-1:0]      csr_wr_data
);

   brc_pkg::brc_cfg_type  cfg_ff, cfg_in;
   logic                  accept;
   logic [1:0]            push_cnt;
   brc_pkg::brc_req_type  push_req0;
   brc_pkg::brc_req_type  push_req1;
   logic                  head_valid;
   brc_pkg::brc_req_type  head_req;
   logic                  pop;
   logic                  almost_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            brc_pkg::CsrPartitionStart: cfg_in.partition_start = csr_wr_data;
            brc_pkg::CsrSectorsPerBlk:
               cfg_in.sectors_per_block = csr_wr_data[brc_pkg::SpbWidth-1:0];
            brc_pkg::CsrMaxRunBlocks:
               cfg_in.max_run_blocks = csr_wr_data[brc_pkg::LenWidth-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.partition_start   <= brc_pkg::PartitionStartRst;
         cfg_ff.sectors_per_block <= brc_pkg::SectorsPerBlkRst;
         cfg_ff.max_run_blocks    <= brc_pkg::MaxRunBlocksRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = almost_full;
   assign accept    = req_valid && !req_stall;

   brc_coalesce u_coalesce (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .accept        (accept),
      .pointer_value (req_pointer_value),
      .last_in_block (req_last_in_block),
      .push_cnt      (push_cnt),
      .push_req0     (push_req0),
      .push_req1     (push_req1)
   );

   brc_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_cnt    (push_cnt),
      .push_req0   (push_req0),
      .push_req1   (push_req1),
      .pop         (pop),
      .head_valid  (head_valid),
      .head_req    (head_req),
      .almost_full (almost_full)
   );

   brc_sector u_sector (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .head_valid        (head_valid),
      .head_req          (head_req),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_start_block   (rsp_start_block),
      .rsp_block_count   (rsp_block_count),
      .rsp_start_sector  (rsp_start_sector),
      .rsp_sector_count  (rsp_sector_count),
      .rsp_final_request (rsp_final_request)
   );

`ifndef ASSERT_OFF
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_block_count != '0) && (rsp_block_count <= brc_pkg::RunCap))
      else $error("response block count out of range");
`endif

endmodule
